// ===== design/mf3e_pkg.sv =====
// Shared types, constants and the sort-layer function of the 3x3 median filter.
// Used by every module of the filter; depends on nothing else.
package mf3e_pkg;

    localparam int PIX_W          = 8;
    localparam int WIDTH_CFG_W    = 8;
    localparam int HEIGHT_CFG_W   = 11;
    localparam int OUT_ROW_W      = 10;
    localparam int OUT_COL_W      = 7;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_ADDR_W     = 3;
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int MIN_DIM        = 2;

    localparam logic [WIDTH_CFG_W-1:0]  RESET_IMAGE_WIDTH  = 8'd128;
    localparam logic [HEIGHT_CFG_W-1:0] RESET_IMAGE_HEIGHT = 11'd80;

    localparam int WIN_DIM     = 3;
    localparam int NUM_TAPS    = WIN_DIM * WIN_DIM;
    localparam int TAP_IDX_W   = $clog2(NUM_TAPS);
    localparam int SORT_LAYERS = NUM_TAPS;
    localparam int QUEUE_DEPTH = 4;
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    // Positions of the middle values in the sorted window for 9, 6 and 4 taps.
    localparam logic [TAP_IDX_W-1:0] MID_9 = 4'd4;
    localparam logic [TAP_IDX_W-1:0] LO_6  = 4'd2;
    localparam logic [TAP_IDX_W-1:0] HI_6  = 4'd3;
    localparam logic [TAP_IDX_W-1:0] LO_4  = 4'd1;
    localparam logic [TAP_IDX_W-1:0] HI_4  = 4'd2;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_FLUSH = 1'b1
    } req_kind_t;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [NUM_TAPS-1:0] win_t;
    // Sort key: the top bit marks a tap outside the clipped neighborhood.
    typedef logic [PIX_W:0] key_t;
    typedef key_t [NUM_TAPS-1:0] key_vec_t;

    typedef struct packed {
        win_t                 win;
        logic                 row0_in;
        logic                 row2_in;
        logic                 col0_in;
        logic                 row_end;
        logic                 drain;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
    } qentry_t;

    typedef struct packed {
        logic [TAP_IDX_W-1:0] lo_idx;
        logic [TAP_IDX_W-1:0] hi_idx;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 frame_done;
        logic                 last_of_run;
    } res_meta_t;

    // One layer of an odd-even transposition sort; the pairs of a layer are disjoint.
    function automatic key_vec_t sort_layer(input key_vec_t k, input logic odd);
        key_vec_t r;
        r = k;
        for (int i = 0; i < NUM_TAPS - 1; i++)
        begin
            if (i[0] == odd)
            begin
                if (k[i] > k[i+1])
                begin
                    r[i]   = k[i+1];
                    r[i+1] = k[i];
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== design/mf3e_front.sv =====
// Front end of the median filter: frame counters, three rotating row buffers and the window.
// Classifies each word and pushes one window snapshot per result-bearing word.
// Depends on mf3e_pkg.
module mf3e_front #(
    parameter int MAX_WIDTH  = mf3e_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mf3e_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              restart,
    input  logic [mf3e_pkg::WIDTH_CFG_W-1:0]  width_cfg,
    input  logic [mf3e_pkg::HEIGHT_CFG_W-1:0] height_cfg,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [mf3e_pkg::PIX_W-1:0]        pixel_value,
    input  logic [mf3e_pkg::LEVEL_W-1:0]      queue_level,
    output logic                              push,
    output mf3e_pkg::qentry_t                 push_data
);
    import mf3e_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 1);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [1:0]       wbuf_reg, wbuf_next;

    logic [31:0]      w32, wm1_32, h32;
    logic [COL_W-1:0] wm1, cur_col;
    logic [ROW_W-1:0] h;
    logic             drain, row_end, accept, active;
    pix_t             pix;

    pix_t buf0 [MAX_WIDTH];
    pix_t buf1 [MAX_WIDTH];
    pix_t buf2 [MAX_WIDTH];
    pix_t rd0_reg, rd1_reg, rd2_reg;

    logic             s1_valid_reg;
    pix_t             s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_drain_reg;
    logic             s1_row_end_reg;
    logic [1:0]       s1_wbuf_reg;

    win_t win_reg, win_next;
    pix_t newer, older;
    logic [ROW_W-1:0] row_m1;
    logic [COL_W-1:0] col_m1;
    logic [31:0]      row_m1_32, col_32;

    // Clamp the configured geometry into its legal range.
    always_comb
    begin
        w32 = 32'(width_cfg);
        if (w32 < MIN_DIM)
            wm1_32 = 32'(MIN_DIM - 1);
        else if (w32 > MAX_WIDTH)
            wm1_32 = 32'(MAX_WIDTH - 1);
        else
            wm1_32 = w32 - 32'd1;
        h32 = 32'(height_cfg);
        if (h32 < MIN_DIM)
            h32 = 32'(MIN_DIM);
        else if (h32 > MAX_HEIGHT)
            h32 = 32'(MAX_HEIGHT);
        wm1 = wm1_32[COL_W-1:0];
        h   = h32[ROW_W-1:0];
    end

    assign drain    = (row_reg >= h);
    assign cur_col  = (col_reg > wm1) ? wm1 : col_reg;
    assign row_end  = (cur_col == wm1);
    // The queue must hold the word of the previous cycle and this one.
    assign in_stall = ((32'(queue_level) + 32'(s1_valid_reg)) >= 32'(QUEUE_DEPTH));
    assign accept   = in_valid && !in_stall;
    // Flush words inside the image rows are taken and dropped.
    assign active   = accept && (drain || (req_type != REQ_FLUSH));
    assign pix      = drain ? '0 : pixel_value;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        wbuf_next = wbuf_reg;
        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            wbuf_next = '0;
        end
        else if (active)
        begin
            if (row_end)
            begin
                col_next  = '0;
                row_next  = drain ? '0 : row_reg + 1'b1;
                wbuf_next = (drain || (wbuf_reg == 2'd2)) ? 2'd0 : wbuf_reg + 2'd1;
            end
            else
            begin
                col_next = cur_col + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            wbuf_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            wbuf_reg     <= wbuf_next;
            s1_valid_reg <= active;
        end
    end

    // Row buffers rotate per row: one takes the current row, the other two
    // hold the rows one and two above it.
    always_ff @(posedge clk)
    begin
        if (active)
        begin
            case (wbuf_reg)
                2'd0:    buf0[cur_col] <= pix;
                2'd1:    buf1[cur_col] <= pix;
                default: buf2[cur_col] <= pix;
            endcase
            rd0_reg        <= buf0[cur_col];
            rd1_reg        <= buf1[cur_col];
            rd2_reg        <= buf2[cur_col];
            s1_pix_reg     <= pix;
            s1_col_reg     <= cur_col;
            s1_row_reg     <= row_reg;
            s1_drain_reg   <= drain;
            s1_row_end_reg <= row_end;
            s1_wbuf_reg    <= wbuf_reg;
        end
    end

    always_comb
    begin
        case (s1_wbuf_reg)
            2'd0:
            begin
                newer = rd2_reg;
                older = rd1_reg;
            end
            2'd1:
            begin
                newer = rd0_reg;
                older = rd2_reg;
            end
            default:
            begin
                newer = rd1_reg;
                older = rd0_reg;
            end
        endcase
        win_next    = win_reg;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = older;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = newer;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (s1_valid_reg)
            win_reg <= win_next;
    end

    // Results lag the input by one row and one column.
    always_comb
    begin
        row_m1    = s1_row_reg - 1'b1;
        col_m1    = s1_col_reg - 1'b1;
        row_m1_32 = 32'(row_m1);
        col_32    = 32'(s1_col_reg);
        push      = s1_valid_reg && (s1_row_reg != '0) && (s1_col_reg != '0);
        push_data.win     = win_next;
        push_data.row0_in = (s1_row_reg >= ROW_W'(2));
        push_data.row2_in = !s1_drain_reg;
        push_data.col0_in = (col_m1 != '0);
        push_data.row_end = s1_row_end_reg;
        push_data.drain   = s1_drain_reg;
        push_data.row     = row_m1_32[OUT_ROW_W-1:0];
        push_data.col     = col_32[OUT_COL_W-1:0];
    end

endmodule

// ===== design/mf3e_queue.sv =====
// Short queue of window snapshots between the front end and the sort pipeline.
// Depends on mf3e_pkg.
module mf3e_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  mf3e_pkg::qentry_t            push_data,
    input  logic                         pop,
    output mf3e_pkg::qentry_t            head,
    output logic                         q_valid,
    output logic [mf3e_pkg::LEVEL_W-1:0] level
);
    import mf3e_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    qentry_t            entries [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [LEVEL_W-1:0] count_reg;

    assign head    = entries[rd_ptr_reg];
    assign q_valid = (count_reg != '0);
    assign level   = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== design/mf3e_back.sv =====
// Back end of the median filter: issues one or two results per snapshot, sorts the
// clipped window in a pipelined transposition network and holds the output word.
// Depends on mf3e_pkg.
module mf3e_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  mf3e_pkg::qentry_t              head,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mf3e_pkg::PIX_W-1:0]     median_value,
    output logic [mf3e_pkg::OUT_ROW_W-1:0] out_row,
    output logic [mf3e_pkg::OUT_COL_W-1:0] out_col,
    output logic                           frame_done,
    output logic                           last_of_run
);
    import mf3e_pkg::*;

    logic      adv, issue, phase_reg, phase_next;
    logic      rows3, cols3, tap_in;
    key_vec_t  issue_keys;
    res_meta_t issue_meta;

    key_vec_t           keys_reg [SORT_LAYERS+1];
    res_meta_t          meta_reg [SORT_LAYERS+1];
    logic [SORT_LAYERS:0] vld_reg;

    logic                 out_valid_reg;
    pix_t                 median_reg;
    logic [OUT_ROW_W-1:0] row_reg;
    logic [OUT_COL_W-1:0] col_reg;
    logic                 frame_done_reg, last_of_run_reg;

    key_t       lo_key, hi_key;
    logic [PIX_W:0] pair_sum;

    // The whole pipeline moves together unless a result waits at the output.
    assign adv   = !out_valid_reg || !out_stall;
    assign issue = adv && q_valid;
    // A row-end snapshot gives a second result for the last column.
    assign pop   = issue && (phase_reg || !head.row_end);

    always_comb
    begin
        phase_next = phase_reg;
        if (issue)
            phase_next = !phase_reg && head.row_end;
    end

    always_comb
    begin
        issue_keys = '0;
        tap_in     = 1'b0;
        for (int r = 0; r < WIN_DIM; r++)
        begin
            for (int c = 0; c < WIN_DIM; c++)
            begin
                tap_in = ((r != 0) || head.row0_in) &&
                         ((r != WIN_DIM - 1) || head.row2_in) &&
                         ((c != 0) || (!phase_reg && head.col0_in));
                issue_keys[r*WIN_DIM + c] = {!tap_in, head.win[r*WIN_DIM + c]};
            end
        end
        rows3 = head.row0_in && head.row2_in;
        cols3 = !phase_reg && head.col0_in;
        case ({rows3, cols3})
            2'b11:
            begin
                issue_meta.lo_idx = MID_9;
                issue_meta.hi_idx = MID_9;
            end
            2'b10, 2'b01:
            begin
                issue_meta.lo_idx = LO_6;
                issue_meta.hi_idx = HI_6;
            end
            default:
            begin
                issue_meta.lo_idx = LO_4;
                issue_meta.hi_idx = HI_4;
            end
        endcase
        issue_meta.row         = head.row;
        issue_meta.col         = phase_reg ? head.col : head.col - 1'b1;
        issue_meta.frame_done  = phase_reg && head.drain;
        issue_meta.last_of_run = phase_reg || !head.row_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[SORT_LAYERS-1:0], issue};
            out_valid_reg <= vld_reg[SORT_LAYERS];
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            keys_reg[0] <= issue_keys;
            meta_reg[0] <= issue_meta;
            for (int k = 1; k <= SORT_LAYERS; k++)
            begin
                keys_reg[k] <= sort_layer(keys_reg[k-1], (k % 2) == 0);
                meta_reg[k] <= meta_reg[k-1];
            end
        end
    end

    // Excluded taps sort above every pixel, so the middle positions depend
    // only on how many taps are in.
    always_comb
    begin
        lo_key   = keys_reg[SORT_LAYERS][meta_reg[SORT_LAYERS].lo_idx];
        hi_key   = keys_reg[SORT_LAYERS][meta_reg[SORT_LAYERS].hi_idx];
        pair_sum = {1'b0, lo_key[PIX_W-1:0]} + {1'b0, hi_key[PIX_W-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            median_reg      <= pair_sum[PIX_W:1];
            row_reg         <= meta_reg[SORT_LAYERS].row;
            col_reg         <= meta_reg[SORT_LAYERS].col;
            frame_done_reg  <= meta_reg[SORT_LAYERS].frame_done;
            last_of_run_reg <= meta_reg[SORT_LAYERS].last_of_run;
        end
    end

    assign out_valid    = out_valid_reg;
    assign median_value = median_reg;
    assign out_row      = row_reg;
    assign out_col      = col_reg;
    assign frame_done   = frame_done_reg;
    assign last_of_run  = last_of_run_reg;

endmodule

// ===== design/median_filter_3x3_edges_top.sv =====
// Top level of the streaming 3x3 median filter with clipped borders: register port,
// front end, snapshot queue and sort back end. Depends on mf3e_pkg and all mf3e_ modules.
//
//   channel   direction  handshake             word
//   input     in         in_valid / in_stall   req_type, pixel_value
//   result    out        out_valid / out_stall median_value, out_row, out_col,
//                                              frame_done, last_of_run
//   config    in         APB psel / penable    image_width at 0x0, image_height at 0x4
//
// One word is taken per cycle while the queue has room; a last-column word gives
// two results and takes the sort issue slot twice, which the result-free column-zero word
// after it absorbs. Results pass the stage-one, queue, sort and output registers.
// Reset clears counters, queue and pipeline valid bits; the row buffers are not cleared.
// An output stall freezes the sort pipeline; input flows until the four-entry queue fills.
module median_filter_3x3_edges_top #(
    parameter int MAX_WIDTH  = mf3e_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mf3e_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [mf3e_pkg::PIX_W-1:0]      pixel_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mf3e_pkg::PIX_W-1:0]      median_value,
    output logic [mf3e_pkg::OUT_ROW_W-1:0]  out_row,
    output logic [mf3e_pkg::OUT_COL_W-1:0]  out_col,
    output logic                            frame_done,
    output logic                            last_of_run,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mf3e_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mf3e_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mf3e_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import mf3e_pkg::*;

    logic [WIDTH_CFG_W-1:0]  width_reg;
    logic [HEIGHT_CFG_W-1:0] height_reg;
    logic                    cfg_wr;
    reg_index_t              reg_idx;

    logic               push, pop, q_valid;
    qentry_t            push_data, head;
    logic [LEVEL_W-1:0] queue_level;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_IMAGE_WIDTH;
            height_reg <= RESET_IMAGE_HEIGHT;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[WIDTH_CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[HEIGHT_CFG_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    mf3e_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (cfg_wr),
        .width_cfg   (width_reg),
        .height_cfg  (height_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .pixel_value (pixel_value),
        .queue_level (queue_level),
        .push        (push),
        .push_data   (push_data)
    );

    mf3e_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_valid   (q_valid),
        .level     (queue_level)
    );

    mf3e_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .median_value (median_value),
        .out_row      (out_row),
        .out_col      (out_col),
        .frame_done   (frame_done),
        .last_of_run  (last_of_run)
    );

endmodule

// ===== tb/median_filter_3x3_edges_top_tb.sv =====
// Self-checking testbench for the streaming 3x3 median filter with clipped borders.
// Holds its own window and row-store predictor and checks every result word in order;
// depends on mf3e_pkg and median_filter_3x3_edges_top.
`timescale 1ns / 100ps

module median_filter_3x3_edges_top_tb;

    import mf3e_pkg::*;

    localparam int    RANDOM_WORDS  = 1100;
    localparam int    DRAIN_CYCLES  = 40;
    localparam int    REG_STRIDE    = 4;
    localparam int    REPORT_LIMIT  = 10;
    localparam longint RUN_LIMIT_NS = 5_000_000;

    typedef struct packed {
        req_kind_t kind;
        pix_t      pix;
    } word_t;

    typedef struct packed {
        pix_t                 median;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 done;
        logic                 last;
    } result_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic                  req_type    = REQ_PIXEL;
    pix_t                  pixel_value = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    pix_t                  median_value;
    logic [OUT_ROW_W-1:0]  out_row;
    logic [OUT_COL_W-1:0]  out_col;
    logic                  frame_done;
    logic                  last_of_run;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr       = '0;
    logic [CFG_DATA_W-1:0] pwdata      = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state: row stores, window, frame position and register copies.
    pix_t                    older_row [DEF_MAX_WIDTH];
    pix_t                    newer_row [DEF_MAX_WIDTH];
    pix_t                    win [NUM_TAPS];
    int                      row_pos;
    int                      col_pos;
    logic [WIDTH_CFG_W-1:0]  cfg_width  = RESET_IMAGE_WIDTH;
    logic [HEIGHT_CFG_W-1:0] cfg_height = RESET_IMAGE_HEIGHT;

    word_t   words_to_send [$];
    result_t medians_due [$];
    word_t   word_out;
    result_t word_in;
    result_t want;

    int sender_gap_pct;
    int receiver_stall_pct;
    int words_queued;
    int words_taken;
    int results_checked;
    int settings_used;
    int failures;

    median_filter_3x3_edges_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .pixel_value  (pixel_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .median_value (median_value),
        .out_row      (out_row),
        .out_col      (out_col),
        .frame_done   (frame_done),
        .last_of_run  (last_of_run),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int eff_width();
        if (cfg_width < MIN_DIM)
            return MIN_DIM;
        if (cfg_width > DEF_MAX_WIDTH)
            return DEF_MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int eff_height();
        if (cfg_height < MIN_DIM)
            return MIN_DIM;
        if (cfg_height > DEF_MAX_HEIGHT)
            return DEF_MAX_HEIGHT;
        return cfg_height;
    endfunction

    // Words in one frame, the drain row included.
    function automatic int frame_len();
        return eff_width() * (eff_height() + 1);
    endfunction

    function automatic pix_t random_pixel();
        if ($urandom_range(0, 9) < 2)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return pix_t'($urandom_range(0, 255));
    endfunction

    // Median of the taps in rows row_lo..row_hi and columns col_lo..2 of the window.
    function automatic pix_t clipped_median(int row_lo, int row_hi, int col_lo);
        int vals [NUM_TAPS];
        int n;
        int t;
        int j;
        n = 0;
        for (int r = row_lo; r <= row_hi; r++)
        begin
            for (int c = col_lo; c < WIN_DIM; c++)
            begin
                vals[n] = win[r * WIN_DIM + c];
                n++;
            end
        end
        for (int i = 1; i < n; i++)
        begin
            t = vals[i];
            j = i;
            while (j > 0 && vals[j-1] > t)
            begin
                vals[j] = vals[j-1];
                j--;
            end
            vals[j] = t;
        end
        if (n % 2 != 0)
            return pix_t'(vals[n/2]);
        return pix_t'((vals[n/2-1] + vals[n/2]) >> 1);
    endfunction

    task automatic predict_medians(req_kind_t kind, pix_t pix);
        int      w;
        int      h;
        int      r;
        int      c;
        int      row_lo;
        int      row_hi;
        bit      drain;
        bit      row_end;
        result_t res;
        w = eff_width();
        h = eff_height();
        drain = (row_pos >= h);
        // A flush word inside the image rows is dropped without effect.
        if (!drain && kind == REQ_FLUSH)
            return;
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = row_pos;
        if (drain)
            pix = '0;
        for (int k = 0; k < WIN_DIM; k++)
        begin
            win[k*WIN_DIM]     = win[k*WIN_DIM + 1];
            win[k*WIN_DIM + 1] = win[k*WIN_DIM + 2];
        end
        win[WIN_DIM - 1]     = older_row[c];
        win[2 * WIN_DIM - 1] = newer_row[c];
        win[NUM_TAPS - 1]    = pix;
        older_row[c] = newer_row[c];
        newer_row[c] = pix;
        row_end = (c == w - 1);
        if (r >= 1 && c >= 1)
        begin
            row_lo = (r >= 2) ? 0 : 1;
            row_hi = drain ? 1 : 2;
            res.median = clipped_median(row_lo, row_hi, (c >= 2) ? 0 : 1);
            res.row    = OUT_ROW_W'(r - 1);
            res.col    = OUT_COL_W'(c - 1);
            res.done   = 1'b0;
            res.last   = !row_end;
            medians_due.push_back(res);
            // The last column also closes out its own position, the right edge.
            if (row_end)
            begin
                res.median = clipped_median(row_lo, row_hi, 1);
                res.col    = OUT_COL_W'(c);
                res.done   = drain;
                res.last   = 1'b1;
                medians_due.push_back(res);
            end
        end
        if (row_end)
        begin
            col_pos = 0;
            row_pos = drain ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    task automatic note_failure(string what, result_t exp_word, result_t got_word);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%s: expected median %0d row %0d col %0d done %0d last %0d, got median %0d row %0d col %0d done %0d last %0d",
                     what, exp_word.median, exp_word.row, exp_word.col, exp_word.done,
                     exp_word.last, got_word.median, got_word.row, got_word.col,
                     got_word.done, got_word.last);
    endtask

    // Input side: feed queued words, predict at each accepted word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            req_type    <= REQ_PIXEL;
            pixel_value <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_medians(req_kind_t'(req_type), pixel_value);
                words_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (words_to_send.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct)
                begin
                    word_out     = words_to_send.pop_front();
                    in_valid    <= 1'b1;
                    req_type    <= word_out.kind;
                    pixel_value <= word_out.pix;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: random back-pressure and in-order comparison.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                word_in = '{median: median_value, row: out_row, col: out_col,
                            done: frame_done, last: last_of_run};
                if (medians_due.size() == 0)
                begin
                    note_failure("result word with nothing expected", '0, word_in);
                end
                else
                begin
                    want = medians_due.pop_front();
                    if (word_in !== want)
                        note_failure("result word mismatch", want, word_in);
                end
                results_checked++;
            end
            out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    task automatic set_idle(int stage);
        case (stage)
            0:
            begin
                sender_gap_pct     = 25;
                receiver_stall_pct = 66;
            end
            1:
            begin
                sender_gap_pct     = 66;
                receiver_stall_pct = 25;
            end
            default:
            begin
                sender_gap_pct     = 0;
                receiver_stall_pct = 0;
            end
        endcase
    endtask

    // Sampled at the falling edge so the driver's updates at the rising edge are settled.
    task automatic wait_results_drained();
        do
            @(negedge clk);
        while (words_to_send.size() != 0 || in_valid || medians_due.size() != 0);
    endtask

    task automatic wait_quiet();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(REG_STRIDE * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            cfg_width = value[WIDTH_CFG_W-1:0];
        else
            cfg_height = value[HEIGHT_CFG_W-1:0];
        // Any register write restarts the frame.
        row_pos = 0;
        col_pos = 0;
        settings_used++;
        @(negedge clk);
    endtask

    task automatic push_word(req_kind_t kind, pix_t pix);
        word_t wd;
        wd.kind = kind;
        wd.pix  = pix;
        words_to_send.push_back(wd);
    endtask

    // Queues count frame positions from the start of a frame, with a dropped flush word now and
    // then; pause holds the feed halfway until every result so far has come back.
    task automatic queue_words(int count, bit pause);
        int w;
        int len;
        int pos;
        w   = eff_width();
        len = frame_len();
        for (int i = 0; i < count; i++)
        begin
            if (pause && i == count / 2)
                wait_results_drained();
            pos = i % len;
            if (pos < w * eff_height())
            begin
                if ($urandom_range(0, 99) < 4)
                    push_word(REQ_FLUSH, random_pixel());
                push_word(REQ_PIXEL, random_pixel());
            end
            else
            begin
                push_word(req_kind_t'($urandom_range(0, 1)), random_pixel());
            end
            words_queued++;
        end
    endtask

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int setting;
        int count;
        row_pos  = 0;
        col_pos  = 0;
        failures = 0;
        for (int k = 0; k < NUM_TAPS; k++)
            win[k] = '0;
        set_idle(0);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed 3x3 frame: extremes, corners, edges and the center, a dropped flush,
        // and a drain row that mixes pixel and flush words.
        write_register(REG_IMAGE_WIDTH, 3);
        write_register(REG_IMAGE_HEIGHT, 3);
        push_word(REQ_PIXEL, 8'd255);
        push_word(REQ_FLUSH, 8'd90);
        push_word(REQ_PIXEL, 8'd0);
        push_word(REQ_PIXEL, 8'd128);
        push_word(REQ_PIXEL, 8'd1);
        push_word(REQ_PIXEL, 8'd254);
        push_word(REQ_PIXEL, 8'd255);
        push_word(REQ_PIXEL, 8'd0);
        push_word(REQ_PIXEL, 8'd255);
        push_word(REQ_PIXEL, 8'd127);
        push_word(REQ_PIXEL, 8'd200);
        push_word(REQ_FLUSH, 8'd0);
        push_word(REQ_PIXEL, 8'd255);

        setting = 0;
        while (words_queued < RANDOM_WORDS)
        begin
            set_idle(words_queued * 3 / RANDOM_WORDS);
            wait_quiet();
            case (setting)
                0:
                begin
                    // Both registers out of range: clamped to full width and two rows.
                    write_register(REG_IMAGE_WIDTH, 200);
                    write_register(REG_IMAGE_HEIGHT, 1);
                    queue_words(frame_len(), 1'b1);
                end
                1:
                begin
                    write_register(REG_IMAGE_WIDTH, 1);
                    write_register(REG_IMAGE_HEIGHT, 2047);
                    queue_words(64, 1'b0);
                end
                2:
                begin
                    write_register(REG_IMAGE_WIDTH, 255);
                    write_register(REG_IMAGE_HEIGHT, 0);
                    queue_words(140, 1'b0);
                end
                3:
                begin
                    write_register(REG_IMAGE_WIDTH, 0);
                    write_register(REG_IMAGE_HEIGHT, 2);
                    queue_words(4 * frame_len(), 1'b1);
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: write_register(REG_IMAGE_HEIGHT, $urandom_range(0, 10));
                        1: write_register(REG_IMAGE_WIDTH, $urandom_range(0, 22));
                        default:
                        begin
                            write_register(REG_IMAGE_WIDTH, $urandom_range(0, 22));
                            write_register(REG_IMAGE_HEIGHT, $urandom_range(0, 10));
                        end
                    endcase
                    count = $urandom_range(1, 3) * frame_len();
                    // Now and then a frame is cut short by the next register write.
                    if ($urandom_range(0, 4) == 0)
                        count = $urandom_range(1, frame_len() - 1);
                    queue_words(count, ($urandom_range(0, 3) == 0) && count >= 2);
                end
            endcase
            setting++;
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d input words and %0d result words over %0d register writes.",
                 words_taken, results_checked, settings_used);
        $display("Failures seen: %0d.", failures);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mf3e_pkg.sv
design/mf3e_front.sv
design/mf3e_queue.sv
design/mf3e_back.sv
design/median_filter_3x3_edges_top.sv
tb/median_filter_3x3_edges_top_tb.sv
